>>> src/sqa_pkg.sv
// Shared types, widths and arithmetic step functions for the small-angle quaternion update.
// Used by every module of the block but the port-level checker; depends on nothing.
package sqa_pkg;

    localparam int DATA_W     = 32;
    localparam int PROD_W     = 64;
    localparam int PMAG_W     = 63;
    localparam int MAG_W      = 30;
    localparam int SQ_W       = 60;
    localparam int SUM_W      = 62;
    localparam int ROOT_W     = 31;
    localparam int QUO_W      = 31;
    localparam int IDX_W      = 6;
    localparam int NORM_MSB   = 29;
    localparam int Q_SHIFT    = 29;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = QUO_W;
    localparam int LANES      = 4;

    typedef logic [MAG_W-1:0]  mag_t;
    typedef logic [ROOT_W-1:0] root_t;

    typedef struct packed {
        mag_t [LANES-1:0] mag;
        logic [LANES-1:0] neg;
        logic             zero;
    } side_t;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] res;
    } sqrt_t;

    typedef struct packed {
        logic [QUO_W-1:0]  rem;
        logic [QUO_W-1:0]  quo;
    } div_t;

    typedef logic [LANES-1:0][DATA_W-1:0] result_t;

    // Quarter of a product, truncated toward zero.
    function automatic logic signed [PROD_W-1:0] quarter(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        begin
            t = p + (p[PROD_W-1] ? 64'sd3 : 64'sd0);
            return t >>> 2;
        end
    endfunction

    // One digit of the bitwise integer square root, with trial bit 4^k.
    function automatic sqrt_t sqrt_step(input sqrt_t s, input int k);
        logic [63:0] b;
        logic [63:0] t;
        sqrt_t       r;
        begin
            b = 64'd1 << (2 * k);
            t = s.res + b;
            if (s.v >= t)
            begin
                r.v   = s.v - t;
                r.res = (s.res >> 1) + b;
            end
            else
            begin
                r.v   = s.v;
                r.res = s.res >> 1;
            end
            return r;
        end
    endfunction

    // One quotient bit of restoring division by a normalized root.
    function automatic div_t div_step(input div_t d, input logic in_bit, input root_t n);
        logic [QUO_W:0] t;
        div_t           r;
        begin
            t = {d.rem, in_bit};
            if (t >= {1'b0, n})
            begin
                t     = t - {1'b0, n};
                r.quo = {d.quo[QUO_W-2:0], 1'b1};
            end
            else
            begin
                r.quo = {d.quo[QUO_W-2:0], 1'b0};
            end
            r.rem = t[QUO_W-1:0];
            return r;
        end
    endfunction

endpackage

>>> src/sqa_front.sv
// Front pipeline: Hamilton product, sign and magnitude, block normalization and sum of squares.
// Nine register stages; depends on sqa_pkg.
module sqa_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_vld,
    input  logic signed [31:0]             cur_x,
    input  logic signed [31:0]             cur_y,
    input  logic signed [31:0]             cur_z,
    input  logic signed [31:0]             cur_w,
    input  logic signed [31:0]             rot_dx,
    input  logic signed [31:0]             rot_dy,
    input  logic signed [31:0]             rot_dz,
    output logic                           out_vld,
    output logic [sqa_pkg::SUM_W-1:0]      out_sum,
    output sqa_pkg::side_t                 out_side
);

    logic [9:1] vld_reg;

    logic signed [31:0]                  q_reg [4];
    logic signed [63:0]                  prod_reg [12];
    logic signed [63:0]                  qs_reg [4];
    logic signed [63:0]                  t_reg [12];
    logic signed [63:0]                  p_reg [4];
    logic [sqa_pkg::PMAG_W-1:0]          pm_reg [4];
    logic [3:0]                          neg4_reg, neg5_reg, neg6_reg, neg7_reg, neg8_reg;
    logic [3:0]                          neg9_reg;
    logic [sqa_pkg::PMAG_W-1:0]          m5_reg;
    logic [sqa_pkg::PMAG_W-1:0]          pm5_reg [4];
    logic [sqa_pkg::PMAG_W-1:0]          pm6_reg [4];
    logic [sqa_pkg::IDX_W-1:0]           idx_reg;
    logic                                zero6_reg, zero7_reg, zero8_reg, zero9_reg;
    sqa_pkg::mag_t                       mag7_reg [4];
    sqa_pkg::mag_t                       mag8_reg [4];
    sqa_pkg::mag_t                       mag9_reg [4];
    logic [sqa_pkg::SQ_W-1:0]            sq_reg [4];
    logic [sqa_pkg::SUM_W-1:0]           sum_reg;

    logic [sqa_pkg::PMAG_W-1:0]          m_next;
    logic [sqa_pkg::IDX_W-1:0]           idx_next;
    sqa_pkg::mag_t                       mag_next [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[8:1], in_vld};
        end
    end

    always_comb
    begin
        m_next = pm_reg[0];
        for (int i = 1; i < 4; i++)
        begin
            if (pm_reg[i] > m_next)
            begin
                m_next = pm_reg[i];
            end
        end
        idx_next = '0;
        for (int i = 0; i < sqa_pkg::PMAG_W; i++)
        begin
            if (m5_reg[i])
            begin
                idx_next = sqa_pkg::IDX_W'(i);
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            if (idx_reg > sqa_pkg::IDX_W'(sqa_pkg::NORM_MSB))
            begin
                mag_next[i] = sqa_pkg::MAG_W'(pm6_reg[i] >>
                              (idx_reg - sqa_pkg::IDX_W'(sqa_pkg::NORM_MSB)));
            end
            else
            begin
                mag_next[i] = sqa_pkg::MAG_W'(pm6_reg[i] <<
                              (sqa_pkg::IDX_W'(sqa_pkg::NORM_MSB) - idx_reg));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg[0] <= cur_x;
            q_reg[1] <= cur_y;
            q_reg[2] <= cur_z;
            q_reg[3] <= cur_w;
            prod_reg[0]  <= cur_w * rot_dx;
            prod_reg[1]  <= cur_y * rot_dz;
            prod_reg[2]  <= cur_z * rot_dy;
            prod_reg[3]  <= cur_w * rot_dy;
            prod_reg[4]  <= cur_z * rot_dx;
            prod_reg[5]  <= cur_x * rot_dz;
            prod_reg[6]  <= cur_w * rot_dz;
            prod_reg[7]  <= cur_x * rot_dy;
            prod_reg[8]  <= cur_y * rot_dx;
            prod_reg[9]  <= cur_x * rot_dx;
            prod_reg[10] <= cur_y * rot_dy;
            prod_reg[11] <= cur_z * rot_dz;

            for (int i = 0; i < 4; i++)
            begin
                qs_reg[i] <= {{3{q_reg[i][31]}}, q_reg[i], {sqa_pkg::Q_SHIFT{1'b0}}};
            end
            for (int i = 0; i < 12; i++)
            begin
                t_reg[i] <= sqa_pkg::quarter(prod_reg[i]);
            end

            p_reg[0] <= qs_reg[0] + t_reg[0] + t_reg[1] - t_reg[2];
            p_reg[1] <= qs_reg[1] + t_reg[3] + t_reg[4] - t_reg[5];
            p_reg[2] <= qs_reg[2] + t_reg[6] + t_reg[7] - t_reg[8];
            p_reg[3] <= qs_reg[3] - t_reg[9] - t_reg[10] - t_reg[11];

            for (int i = 0; i < 4; i++)
            begin
                neg4_reg[i] <= p_reg[i][63];
                pm_reg[i]   <= p_reg[i][63] ? (~p_reg[i][62:0] + 63'd1) : p_reg[i][62:0];
            end

            m5_reg   <= m_next;
            pm5_reg  <= pm_reg;
            neg5_reg <= neg4_reg;

            idx_reg   <= idx_next;
            zero6_reg <= (m5_reg == '0);
            pm6_reg   <= pm5_reg;
            neg6_reg  <= neg5_reg;

            mag7_reg  <= mag_next;
            zero7_reg <= zero6_reg;
            neg7_reg  <= neg6_reg;

            for (int i = 0; i < 4; i++)
            begin
                sq_reg[i] <= mag7_reg[i] * mag7_reg[i];
            end
            mag8_reg  <= mag7_reg;
            zero8_reg <= zero7_reg;
            neg8_reg  <= neg7_reg;

            sum_reg   <= sqa_pkg::SUM_W'(sq_reg[0]) + sqa_pkg::SUM_W'(sq_reg[1]) +
                         sqa_pkg::SUM_W'(sq_reg[2]) + sqa_pkg::SUM_W'(sq_reg[3]);
            mag9_reg  <= mag8_reg;
            zero9_reg <= zero8_reg;
            neg9_reg  <= neg8_reg;
        end
    end

    assign out_vld       = vld_reg[9];
    assign out_sum       = sum_reg;
    assign out_side.neg  = neg9_reg;
    assign out_side.zero = zero9_reg;
    assign out_side.mag  = {mag9_reg[3], mag9_reg[2], mag9_reg[1], mag9_reg[0]};

endmodule

>>> src/sqa_sqrt.sv
// Pipelined integer square root, one root digit per register stage.
// Carries the lane magnitudes and flags alongside; depends on sqa_pkg.
module sqa_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_vld,
    input  logic [sqa_pkg::SUM_W-1:0]      in_sum,
    input  sqa_pkg::side_t                 in_side,
    output logic                           out_vld,
    output sqa_pkg::root_t                 out_root,
    output sqa_pkg::side_t                 out_side
);

    localparam int N = sqa_pkg::SQRT_STEPS;

    sqa_pkg::sqrt_t st_reg [N];
    sqa_pkg::side_t sd_reg [N];
    logic [N-1:0]   vld_reg;
    sqa_pkg::sqrt_t init;

    assign init.v   = 64'(in_sum);
    assign init.res = '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_vld};
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_step
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[k] <= sqa_pkg::sqrt_step(init, N - 1);
                    sd_reg[k] <= in_side;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[k] <= sqa_pkg::sqrt_step(st_reg[k-1], N - 1 - k);
                    sd_reg[k] <= sd_reg[k-1];
                end
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_root = st_reg[N-1].res[sqa_pkg::ROOT_W-1:0];
    assign out_side = sd_reg[N-1];

endmodule

>>> src/sqa_div.sv
// Four-lane pipelined restoring divider: each lane magnitude scaled by 2^30 over the root.
// Applies signs and the zero-product case at its output; depends on sqa_pkg.
module sqa_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_vld,
    input  sqa_pkg::root_t                 in_root,
    input  sqa_pkg::side_t                 in_side,
    output logic                           out_vld,
    output sqa_pkg::result_t               out_res
);

    localparam int N = sqa_pkg::DIV_STEPS;

    sqa_pkg::div_t  dv_reg [N][sqa_pkg::LANES];
    sqa_pkg::root_t n_reg [N];
    logic [3:0]     neg_reg [N];
    logic           zero_reg [N];
    logic [N-1:0]   vld_reg;
    sqa_pkg::div_t  init [sqa_pkg::LANES];

    always_comb
    begin
        for (int i = 0; i < sqa_pkg::LANES; i++)
        begin
            init[i].rem = {2'b00, in_side.mag[i][sqa_pkg::MAG_W-1:1]};
            init[i].quo = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_vld};
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_step
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int i = 0; i < sqa_pkg::LANES; i++)
                    begin
                        dv_reg[k][i] <= sqa_pkg::div_step(init[i], in_side.mag[i][0], in_root);
                    end
                    n_reg[k]    <= in_root;
                    neg_reg[k]  <= in_side.neg;
                    zero_reg[k] <= in_side.zero;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int i = 0; i < sqa_pkg::LANES; i++)
                    begin
                        dv_reg[k][i] <= sqa_pkg::div_step(dv_reg[k-1][i], 1'b0, n_reg[k-1]);
                    end
                    n_reg[k]    <= n_reg[k-1];
                    neg_reg[k]  <= neg_reg[k-1];
                    zero_reg[k] <= zero_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < sqa_pkg::LANES; i++)
        begin
            if (zero_reg[N-1])
            begin
                out_res[i] = '0;
            end
            else if (neg_reg[N-1][i])
            begin
                out_res[i] = ~{1'b0, dv_reg[N-1][i].quo} + 32'd1;
            end
            else
            begin
                out_res[i] = {1'b0, dv_reg[N-1][i].quo};
            end
        end
    end

    assign out_vld = vld_reg[N-1];

endmodule

>>> src/sqa_skid.sv
// Output register with one skid entry, which takes one item when the output stalls so the pipeline can move on.
// Depends on sqa_pkg for the result type.
module sqa_skid (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_vld,
    output logic                   in_rdy,
    input  sqa_pkg::result_t       in_res,
    output logic                   out_vld,
    input  logic                   out_rdy,
    output sqa_pkg::result_t       out_res
);

    logic             out_vld_reg, skid_vld_reg;
    sqa_pkg::result_t out_res_reg, skid_res_reg;
    logic             push;

    assign in_rdy = !skid_vld_reg;
    assign push   = in_vld && !skid_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || out_rdy)
        begin
            out_vld_reg  <= skid_vld_reg || push;
            skid_vld_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || out_rdy)
        begin
            out_res_reg <= skid_vld_reg ? skid_res_reg : in_res;
        end
        else if (push)
        begin
            skid_res_reg <= in_res;
        end
    end

    assign out_vld = out_vld_reg;
    assign out_res = out_res_reg;

endmodule

>>> src/quaternion_small_angle_update.sv
// Top level of the small-angle quaternion update: product, normalization, root and division.
// Instantiates sqa_front, sqa_sqrt, sqa_div and sqa_skid; depends on sqa_pkg.
// The block takes one item per cycle while it is not stalled; each result passes through
// 9 front stages, 32 square root stages, 31 divider stages and the output register. The
// whole pipeline advances together and freezes only while the one-entry skid stage behind
// the output register is full.
module quaternion_small_angle_update (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] cur_x,
    input  logic signed [31:0] cur_y,
    input  logic signed [31:0] cur_z,
    input  logic signed [31:0] cur_w,
    input  logic signed [31:0] rot_dx,
    input  logic signed [31:0] rot_dy,
    input  logic signed [31:0] rot_dz,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_x,
    output logic signed [31:0] new_y,
    output logic signed [31:0] new_z,
    output logic signed [31:0] new_w
);

    logic                          en;
    logic                          f_vld, s_vld, d_vld;
    logic [sqa_pkg::SUM_W-1:0]     f_sum;
    sqa_pkg::side_t                f_side, s_side;
    sqa_pkg::root_t                s_root;
    sqa_pkg::result_t              d_res, o_res;

    assign in_ready = en;

    sqa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_valid),
        .cur_x    (cur_x),
        .cur_y    (cur_y),
        .cur_z    (cur_z),
        .cur_w    (cur_w),
        .rot_dx   (rot_dx),
        .rot_dy   (rot_dy),
        .rot_dz   (rot_dz),
        .out_vld  (f_vld),
        .out_sum  (f_sum),
        .out_side (f_side)
    );

    sqa_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (f_vld),
        .in_sum   (f_sum),
        .in_side  (f_side),
        .out_vld  (s_vld),
        .out_root (s_root),
        .out_side (s_side)
    );

    sqa_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s_vld),
        .in_root (s_root),
        .in_side (s_side),
        .out_vld (d_vld),
        .out_res (d_res)
    );

    sqa_skid u_skid (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (d_vld),
        .in_rdy  (en),
        .in_res  (d_res),
        .out_vld (out_valid),
        .out_rdy (out_ready),
        .out_res (o_res)
    );

    assign new_x = o_res[0];
    assign new_y = o_res[1];
    assign new_z = o_res[2];
    assign new_w = o_res[3];

endmodule

>>> src/sqa_checker.sv
// Port-level checker for the small-angle quaternion update, bound to the top level.
// Depends only on the top level's ports.
module sqa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] new_x,
    input logic [31:0] new_y,
    input logic [31:0] new_z,
    input logic [31:0] new_w
);

    localparam logic signed [31:0] ONE = 32'sh4000_0000;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(new_x) && $stable(new_y) && $stable(new_z)
                                    && $stable(new_w))
        else $error("result item changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $signed(new_x) <= ONE && $signed(new_x) >= -ONE
                   && $signed(new_w) <= ONE && $signed(new_w) >= -ONE)
        else $error("normalized component out of range");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("input stalled without output backpressure");

endmodule

bind quaternion_small_angle_update sqa_checker u_sqa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .new_x     (new_x),
    .new_y     (new_y),
    .new_z     (new_z),
    .new_w     (new_w)
);

>>> test/tb.sv
// Self-checking testbench for quaternion_small_angle_update: directed table, then random items.
// Checks each result by table or by fixed-point predictor; depends on sqa_pkg and the RTL.
`timescale 1ns / 100ps

module tb;

    typedef logic signed [sqa_pkg::DATA_W-1:0] word_t;

    typedef struct {
        word_t x;
        word_t y;
        word_t z;
        word_t w;
    } quat_t;

    typedef struct {
        word_t cx, cy, cz, cw, rx, ry, rz;
        bit    typed;
        quat_t res;
    } stim_t;

    localparam int DIR_N   = 14;
    localparam int RAND_N  = 1400;
    localparam word_t ONE  = 32'sh4000_0000;
    localparam word_t MAXV = 32'sh7fff_ffff;
    localparam word_t MINV = 32'sh8000_0000;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    word_t cur_x, cur_y, cur_z, cur_w, rot_dx, rot_dy, rot_dz;
    logic  out_valid;
    logic  out_ready;
    word_t new_x, new_y, new_z, new_w;

    quat_t pending_q[$];
    stim_t dir_tab[DIR_N];
    int    errors;
    int    n_sent;
    int    n_recv;
    int    n_zero;
    bit    calm;

    quaternion_small_angle_update u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cur_x(cur_x), .cur_y(cur_y), .cur_z(cur_z), .cur_w(cur_w),
        .rot_dx(rot_dx), .rot_dy(rot_dy), .rot_dz(rot_dz),
        .out_valid(out_valid), .out_ready(out_ready),
        .new_x(new_x), .new_y(new_y), .new_z(new_z), .new_w(new_w)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        begin
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        end
    endfunction

    function automatic quat_t rotate_norm(input stim_t s);
        logic signed [63:0] qx, qy, qz, qw, dx, dy, dz;
        logic signed [63:0] p[4];
        logic [63:0]        mg[4];
        bit                 ng[4];
        logic [63:0]        m, sum, n, o;
        int                 rs, ls;
        word_t              r[4];
        quat_t              q;
        begin
            qx = s.cx; qy = s.cy; qz = s.cz; qw = s.cw;
            dx = s.rx; dy = s.ry; dz = s.rz;
            p[0] = qx * 64'sd536870912 + (qw * dx) / 4 + (qy * dz) / 4 - (qz * dy) / 4;
            p[1] = qy * 64'sd536870912 + (qw * dy) / 4 + (qz * dx) / 4 - (qx * dz) / 4;
            p[2] = qz * 64'sd536870912 + (qw * dz) / 4 + (qx * dy) / 4 - (qy * dx) / 4;
            p[3] = qw * 64'sd536870912 - (qx * dx) / 4 - (qy * dy) / 4 - (qz * dz) / 4;
            m = 0;
            sum = 0;
            rs = 0;
            ls = 0;
            for (int i = 0; i < 4; i++)
            begin
                ng[i] = p[i] < 0;
                mg[i] = ng[i] ? -p[i] : p[i];
                if (mg[i] > m)
                    m = mg[i];
            end
            if (m == 0)
            begin
                q = '{0, 0, 0, 0};
                return q;
            end
            while ((m >> rs) >= (64'd1 << 30))
                rs++;
            if (rs == 0)
                while ((m << ls) < (64'd1 << 29))
                    ls++;
            for (int i = 0; i < 4; i++)
            begin
                mg[i] = rs != 0 ? (mg[i] >> rs) : (mg[i] << ls);
                sum = sum + mg[i] * mg[i];
            end
            n = root64(sum);
            for (int i = 0; i < 4; i++)
            begin
                o = (mg[i] << 30) / n;
                r[i] = ng[i] ? -o[31:0] : o[31:0];
            end
            q = '{r[0], r[1], r[2], r[3]};
            return q;
        end
    endfunction

    function automatic int idle_cycles();
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic word_t small_rot();
        word_t v;
        begin
            v = $urandom;
            return v >>> $urandom_range(8, 31);
        end
    endfunction

    function automatic stim_t random_item();
        stim_t s;
        int    k;
        begin
            k = $urandom_range(0, 9);
            s.typed = 1'b0;
            s.res = '{0, 0, 0, 0};
            s.cx = $urandom; s.cy = $urandom; s.cz = $urandom; s.cw = $urandom;
            s.rx = $urandom; s.ry = $urandom; s.rz = $urandom;
            if (k < 8)
            begin
                s.cx = s.cx >>> 2; s.cy = s.cy >>> 2;
                s.cz = s.cz >>> 2; s.cw = s.cw >>> 1;
                s.rx = small_rot(); s.ry = small_rot(); s.rz = small_rot();
                if (k == 0)
                begin
                    s.cx = s.cx >>> 20; s.cy = s.cy >>> 20;
                    s.cz = s.cz >>> 20; s.cw = s.cw >>> 20;
                end
            end
            return s;
        end
    endfunction

    task automatic send_item(input stim_t s);
        int gap;
        begin
            gap = idle_cycles();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            cur_x <= s.cx; cur_y <= s.cy; cur_z <= s.cz; cur_w <= s.cw;
            rot_dx <= s.rx; rot_dy <= s.ry; rot_dz <= s.rz;
            do
                @(posedge clk);
            while (!in_ready);
            pending_q.push_back(s.typed ? s.res : rotate_norm(s));
            n_sent++;
        end
    endtask

    initial
    begin
        int gap;
        quat_t e;
        forever
        begin
            gap = idle_cycles();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && rst_n));
            n_recv++;
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected item: %h %h %h %h", new_x, new_y, new_z, new_w);
            end
            else
            begin
                e = pending_q.pop_front();
                if (e.x == 0 && e.y == 0 && e.z == 0 && e.w == 0)
                    n_zero++;
                if (new_x !== e.x || new_y !== e.y || new_z !== e.z || new_w !== e.w)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch item %0d: exp %h %h %h %h got %h %h %h %h",
                                 n_recv, e.x, e.y, e.z, e.w, new_x, new_y, new_z, new_w);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        int wait_n;
        errors = 0; n_sent = 0; n_recv = 0; n_zero = 0; calm = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cur_x = 0; cur_y = 0; cur_z = 0; cur_w = 0;
        rot_dx = 0; rot_dy = 0; rot_dz = 0;

        dir_tab[0]  = '{0, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0}};
        dir_tab[1]  = '{0, 0, 0, ONE, 0, 0, 0, 1, '{0, 0, 0, ONE}};
        dir_tab[2]  = '{0, 0, 0, -ONE, 0, 0, 0, 1, '{0, 0, 0, -ONE}};
        dir_tab[3]  = '{ONE, 0, 0, 0, 0, 0, 0, 1, '{ONE, 0, 0, 0}};
        dir_tab[4]  = '{0, -ONE, 0, 0, 0, 0, 0, 1, '{0, -ONE, 0, 0}};
        dir_tab[5]  = '{0, 0, ONE, 0, 0, 0, 0, 1, '{0, 0, ONE, 0}};
        dir_tab[6]  = '{0, 0, 0, 0, MAXV, MINV, MAXV, 1, '{0, 0, 0, 0}};
        dir_tab[7]  = '{0, 0, 0, ONE, 32'sh0010_0000, -32'sh0008_0000, 32'sh0000_1000,
                        0, '{0, 0, 0, 0}};
        dir_tab[8]  = '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 0, '{0, 0, 0, 0}};
        dir_tab[9]  = '{MINV, MINV, MINV, MINV, MINV, MINV, MINV, 0, '{0, 0, 0, 0}};
        dir_tab[10] = '{MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV, 0, '{0, 0, 0, 0}};
        dir_tab[11] = '{1, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0}};
        dir_tab[12] = '{0, 0, 0, -1, 1, -1, 1, 0, '{0, 0, 0, 0}};
        dir_tab[13] = '{32'sh2000_0000, 0, 0, 32'sh2000_0000, ONE, ONE, ONE, 0, '{0, 0, 0, 0}};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_item(dir_tab[i]);

        for (int i = 0; i < RAND_N; i++)
        begin
            if (i % 150 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (i == RAND_N / 2)
            begin
                in_valid <= 1'b0;
                wait_n = 0;
                while (pending_q.size() != 0 && wait_n < 20000)
                begin
                    @(posedge clk);
                    wait_n++;
                end
            end
            send_item(random_item());
        end
        in_valid <= 1'b0;

        wait_n = 0;
        while (pending_q.size() != 0 && wait_n < 20000)
        begin
            @(posedge clk);
            wait_n++;
        end
        repeat (100) @(posedge clk);

        $display("covered %0d items (%0d directed), %0d results, %0d zero products",
                 n_sent, DIR_N, n_recv, n_zero);
        if (errors == 0 && pending_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
